// ===== design/b2da_pkg.sv =====
// Package for the binary to decimal ASCII unit.
// Shared constants and the converter-to-emitter transfer type; no dependencies.
package b2da_pkg;

    localparam int FIELD_BITS     = 32;     // width of the input value port
    localparam int VALUE_BITS_DEF = 32;     // default number of value bits used
    localparam int DIGITS         = 10;     // decimal digits of a 32-bit value
    localparam int DIGIT_W        = 4;
    localparam int BCD_W          = DIGITS * DIGIT_W;
    localparam int IDX_W          = $clog2(DIGITS);
    localparam int CHAR_W         = 6;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W-1:0] DAB_LIMIT  = 4'd5;
    localparam logic [DIGIT_W-1:0] DAB_ADJ    = 4'd3;

    // finished BCD word from the converter
    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
    } t_bcd_xfer;

endpackage

// ===== design/b2da_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on b2da_pkg.
module b2da_dabble #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [b2da_pkg::FIELD_BITS-1:0] i_value,
    output b2da_pkg::t_bcd_xfer             o_xfer,
    input  logic                            i_take
);

    localparam int EFF   = (VALUE_BITS < b2da_pkg::FIELD_BITS) ? VALUE_BITS
                                                                : b2da_pkg::FIELD_BITS;
    localparam int CNT_W = $clog2(EFF + 1);
    localparam int BW    = b2da_pkg::BCD_W;
    localparam int DW    = b2da_pkg::DIGIT_W;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} t_state;

    t_state           r_state;
    logic [EFF-1:0]   r_bin, n_bin;
    logic [BW-1:0]    r_bcd, n_bcd;
    logic [CNT_W-1:0] r_cnt;
    logic [BW-1:0]    corr;

    // add 3 to every digit of 5 or more, then shift the next bit in
    always_comb begin
        for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
            if (r_bcd[i*DW +: DW] >= b2da_pkg::DAB_LIMIT) begin
                corr[i*DW +: DW] = r_bcd[i*DW +: DW] + b2da_pkg::DAB_ADJ;
            end else begin
                corr[i*DW +: DW] = r_bcd[i*DW +: DW];
            end
        end
        n_bcd = {corr[BW-2:0], r_bin[EFF-1]};
        n_bin = r_bin << 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_bin   <= i_value[EFF-1:0];
                        r_bcd   <= '0;
                        r_cnt   <= CNT_W'(EFF);
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_bin <= n_bin;
                    r_bcd <= n_bcd;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_xfer.valid = (r_state == S_HOLD);
    assign o_xfer.bcd   = r_bcd;

endmodule

// ===== design/b2da_emit.sv =====
// Digit emitter: shifts BCD digits out most significant first, drops leading
// zeros, drives the output word register. Depends on b2da_pkg.
module b2da_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  b2da_pkg::t_bcd_xfer               i_xfer,
    output logic                              o_take,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [b2da_pkg::CHAR_W-1:0]       o_digit_char,
    output logic                              o_last
);

    localparam int BW = b2da_pkg::BCD_W;
    localparam int DW = b2da_pkg::DIGIT_W;
    localparam int XW = b2da_pkg::IDX_W;

    typedef enum logic {S_IDLE, S_EMIT} t_state;

    t_state                       r_state;
    logic [BW-1:0]                r_sh;
    logic [XW-1:0]                r_idx;
    logic                         r_lead;
    logic                         r_valid;
    logic [b2da_pkg::CHAR_W-1:0]  r_char;
    logic                         r_last;
    logic [DW-1:0]                top_dig;
    logic                         out_free;
    logic                         skip_zero;
    logic                         emit_now;

    assign top_dig   = r_sh[BW-1 -: DW];
    assign out_free  = !r_valid || i_ready;
    assign o_take    = (r_state == S_IDLE) && i_xfer.valid;
    // leading zero, never the last digit
    assign skip_zero = r_lead && (top_dig == '0) && (r_idx != '0);
    assign emit_now  = (r_state == S_EMIT) && !skip_zero && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_lead  <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (emit_now) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_xfer.valid) begin
                        r_sh    <= i_xfer.bcd;
                        r_idx   <= XW'(b2da_pkg::DIGITS - 1);
                        r_lead  <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (skip_zero) begin
                        // leading zero, skip it
                        r_sh  <= r_sh << DW;
                        r_idx <= r_idx - 1'b1;
                    end else if (out_free) begin
                        r_char  <= b2da_pkg::ASCII_ZERO
                                   + {{(b2da_pkg::CHAR_W-DW){1'b0}}, top_dig};
                        r_last  <= (r_idx == '0);
                        r_lead  <= 1'b0;
                        r_sh    <= r_sh << DW;
                        r_idx   <= r_idx - 1'b1;
                        if (r_idx == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_digit_char = r_char;
    assign o_last       = r_last;

endmodule

// ===== design/binary_to_decimal_ascii_unit.sv =====
// Binary to decimal ASCII unit: the first digit of a value leaves after the
// conversion, the hand-off and the skip of any leading zero digits (up to 9).
// The converter can start the next value while the emitter still sends the
// last one; digits leave one per cycle while the output is ready.
// Conversion runs the bit-serial shift/add-3 loop, one value bit a cycle.
// Reset (synchronous, active low) returns both stages to idle, no word pending.
module binary_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input word channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [b2da_pkg::FIELD_BITS-1:0] i_value,
    // output word channel, one ASCII digit per word
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [b2da_pkg::CHAR_W-1:0]     o_digit_char,
    output logic                            o_last
);

    // BCD word hand-off between converter and emitter; the converter may
    // start the next value as soon as the emitter has taken the word.
    b2da_pkg::t_bcd_xfer xfer;
    logic                take;

    // stage 1: shift/add-3 converter, bits above VALUE_BITS ignored
    b2da_dabble #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_xfer  (xfer),
        .i_take  (take)
    );

    // stage 2: digit buffer, leading-zero skip and output register;
    // zero gives the single digit '0' since the last digit is never skipped
    b2da_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_xfer       (xfer),
        .o_take       (take),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule
